/* hw/rtl/rfd_pkg.sv */
// rfd_pkg: constants, register indexes and shared types for the RF record deframer.
// Used by rfd_track and rf_record_deframer. No dependencies.
`timescale 1ns / 1ps

package rfd_pkg;

  localparam int unsigned MAX_LINES    = 256;
  localparam int unsigned MAX_CHANNELS = 128;
  localparam int unsigned MAX_SAMPLES  = 8192;
  localparam int unsigned FRONT_GROUP  = 16;
  localparam int unsigned HEADER_WORDS = 4;

  localparam logic [15:0] DATA_BIAS = 16'd2048;

  typedef enum logic [2:0] {
    REG_LINES    = 3'd0,
    REG_CHANNELS = 3'd1,
    REG_SAMPLES  = 3'd2,
    REG_SKIP     = 3'd3,
    REG_EMIT     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [8:0]  lines_per_frame;
    logic [7:0]  channel_count;
    logic [13:0] sample_count;
    logic [15:0] frames_to_skip;
    logic [15:0] frames_to_emit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] sample_value;
    logic [15:0] frame_index;
    logic [7:0]  line_index;
    logic [6:0]  channel_index;
    logic [12:0] sample_index;
    logic        last_of_all;
  } result_t;

endpackage

/* hw/rtl/rfd_track.sv */
// rfd_track: frame, line, record and word counters; tags each data word.
// Depends on rfd_pkg.
`timescale 1ns / 1ps

module rfd_track (
  input  logic            clk,
  input  logic            rst_n,
  input  rfd_pkg::cfg_t   cfg,
  input  logic            step,
  input  logic [15:0]     raw_word,
  output logic            emit,
  output rfd_pkg::result_t res
);
  import rfd_pkg::*;

  logic [15:0] skipped_r, skipped_nxt;
  logic [15:0] frame_r,   frame_nxt;
  logic [7:0]  line_r,    line_nxt;
  logic [6:0]  rec_r,     rec_nxt;
  logic [13:0] word_r,    word_nxt;
  logic        fin_r,     fin_nxt;

  logic [8:0]  nl;
  logic [7:0]  nc;
  logic [13:0] ns;
  logic [14:0] rec_words;
  logic [7:0]  back;
  logic        emitting, done_now, wlast, rlast, llast, flast, last;
  logic [13:0] data_pos;

  always_comb begin
    if (cfg.lines_per_frame < 9'd1) nl = 9'd1;
    else if (cfg.lines_per_frame > 9'(MAX_LINES)) nl = 9'(MAX_LINES);
    else nl = cfg.lines_per_frame;

    if (cfg.channel_count < 8'(FRONT_GROUP + 1)) nc = 8'(FRONT_GROUP + 1);
    else if (cfg.channel_count > 8'(MAX_CHANNELS)) nc = 8'(MAX_CHANNELS);
    else nc = cfg.channel_count;

    if (cfg.sample_count < 14'd2) ns = 14'd2;
    else if (cfg.sample_count > 14'(MAX_SAMPLES)) ns = 14'(MAX_SAMPLES);
    else ns = cfg.sample_count;
  end

  assign rec_words = 15'(HEADER_WORDS) + {1'b0, ns} - 15'd1;
  assign back      = nc - 8'(FRONT_GROUP);

  assign emitting = skipped_r >= cfg.frames_to_skip;
  assign done_now = emitting && (frame_r >= cfg.frames_to_emit);
  assign wlast    = ({1'b0, word_r} + 15'd1) >= rec_words;
  assign rlast    = ({1'b0, rec_r} + 8'd1) >= nc;
  assign llast    = ({1'b0, line_r} + 9'd1) >= nl;
  assign flast    = ({1'b0, frame_r} + 17'd1) >= {1'b0, cfg.frames_to_emit};
  assign last     = emitting && wlast && rlast && llast && flast;

  assign emit     = !fin_r && !done_now && emitting && (word_r >= 14'(HEADER_WORDS));
  assign data_pos = word_r - 14'(HEADER_WORDS);

  always_comb begin
    res.sample_value = raw_word - DATA_BIAS;
    res.frame_index  = frame_r;
    res.line_index   = line_r;
    res.channel_index = ({1'b0, rec_r} < back) ? rec_r + 7'(FRONT_GROUP)
                                               : rec_r - back[6:0];
    res.sample_index = data_pos[12:0];
    res.last_of_all  = last;
  end

  always_comb begin
    skipped_nxt = skipped_r;
    frame_nxt   = frame_r;
    line_nxt    = line_r;
    rec_nxt     = rec_r;
    word_nxt    = word_r;
    fin_nxt     = fin_r;
    if (step && !fin_r) begin
      if (done_now) begin
        fin_nxt = 1'b1;
      end else begin
        if (wlast) begin
          word_nxt = '0;
          if (rlast) begin
            rec_nxt = '0;
            if (llast) begin
              line_nxt = '0;
              if (emitting) frame_nxt = frame_r + 16'd1;
              else skipped_nxt = skipped_r + 16'd1;
            end else begin
              line_nxt = line_r + 8'd1;
            end
          end else begin
            rec_nxt = rec_r + 7'd1;
          end
        end else begin
          word_nxt = word_r + 14'd1;
        end
        if (last) fin_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skipped_r <= '0;
      frame_r   <= '0;
      line_r    <= '0;
      rec_r     <= '0;
      word_r    <= '0;
      fin_r     <= 1'b0;
    end else begin
      skipped_r <= skipped_nxt;
      frame_r   <= frame_nxt;
      line_r    <= line_nxt;
      rec_r     <= rec_nxt;
      word_r    <= word_nxt;
      fin_r     <= fin_nxt;
    end
  end

endmodule

/* hw/rtl/rf_record_deframer.sv */
// rf_record_deframer: top level; config registers, handshakes and output register.
// Depends on rfd_pkg and rfd_track.
//
//  channel | signals                              | direction
//  in      | in_valid, in_ready, in_raw_word      | word in
//  out     | out_valid, out_ready, out_* tags     | tagged sample out
//  cfg     | cfg_we, cfg_index, cfg_wdata         | register write
//
// One word per cycle while the output is not stalled; out_valid rises in the
// cycle after accept, and the output register is the only stage. in_ready is
// high whenever the output register is empty or being taken. Synchronous
// active-low reset clears counters and valid. Header words, skipped frames
// and words after the final frame are consumed without output.
`timescale 1ns / 1ps

module rf_record_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_raw_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_sample_value,
  output logic [15:0] out_frame_index,
  output logic [7:0]  out_line_index,
  output logic [6:0]  out_channel_index,
  output logic [12:0] out_sample_index,
  output logic        out_last_of_all,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import rfd_pkg::*;

  cfg_t    cfg_r;
  result_t res, res_r;
  logic    out_valid_r;
  logic    step, emit;

  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  rfd_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .step     (step),
    .raw_word (in_raw_word),
    .emit     (emit),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lines_per_frame <= 9'd1;
      cfg_r.channel_count   <= 8'd96;
      cfg_r.sample_count    <= 14'd2048;
      cfg_r.frames_to_skip  <= 16'd1;
      cfg_r.frames_to_emit  <= 16'd1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LINES:    cfg_r.lines_per_frame <= cfg_wdata[8:0];
        REG_CHANNELS: cfg_r.channel_count   <= cfg_wdata[7:0];
        REG_SAMPLES:  cfg_r.sample_count    <= cfg_wdata[13:0];
        REG_SKIP:     cfg_r.frames_to_skip  <= cfg_wdata;
        REG_EMIT:     cfg_r.frames_to_emit  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) res_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_sample_value  = res_r.sample_value;
  assign out_frame_index   = res_r.frame_index;
  assign out_line_index    = res_r.line_index;
  assign out_channel_index = res_r.channel_index;
  assign out_sample_index  = res_r.sample_index;
  assign out_last_of_all   = res_r.last_of_all;

endmodule

/* hw/rtl/rfd_checker.sv */
// rfd_checker: port-level checks for rf_record_deframer, bound to the top level.
// Depends on rf_record_deframer ports only.
`timescale 1ns / 1ps

module rfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] in_raw_word,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample_value,
  input logic [15:0] out_frame_index,
  input logic [7:0]  out_line_index,
  input logic [6:0]  out_channel_index,
  input logic [12:0] out_sample_index,
  input logic        out_last_of_all,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [15:0] cfg_wdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_value)
      && $stable(out_sample_index) && $stable(out_last_of_all))
    else $error("stalled output word changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled output");

  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_of_all |=> !out_valid)
    else $error("word emitted after the final word");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample_index != 13'h1FFF)
    else $error("sample index out of range");

endmodule

bind rf_record_deframer rfd_checker u_rfd_checker (.*);
